/* src/masked_window_grid_select_unit_macros.svh */
// Assertion macros for the masked window grid selector checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef MASKED_WINDOW_GRID_SELECT_UNIT_MACROS_SVH
`define MASKED_WINDOW_GRID_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MWGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MWGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mwgs_pkg.sv */
// Shared constants, register codes and types for the masked window grid selector.
// No dependencies.
`timescale 1ns / 1ps

package mwgs_pkg;

    localparam int PIX_W      = 10;
    localparam int ALPHA_W    = 8;
    localparam int WSIZE_W    = 8;
    localparam int APB_DW     = 32;
    localparam int CFG_AW     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;
    localparam int MAX_WINDOW_DEF   = 128;

    localparam logic [PIX_W-1:0]   ROI_LEFT_RST   = PIX_W'(0);
    localparam logic [PIX_W-1:0]   ROI_TOP_RST    = PIX_W'(0);
    localparam logic [PIX_W-1:0]   ROI_RIGHT_RST  = PIX_W'(1023);
    localparam logic [PIX_W-1:0]   ROI_BOTTOM_RST = PIX_W'(1023);
    localparam logic [PIX_W-1:0]   STEP_X_RST     = PIX_W'(16);
    localparam logic [PIX_W-1:0]   STEP_Y_RST     = PIX_W'(16);
    localparam logic [WSIZE_W-1:0] WIN_WIDTH_RST  = WSIZE_W'(32);
    localparam logic [WSIZE_W-1:0] WIN_HEIGHT_RST = WSIZE_W'(32);

    typedef enum logic [2:0] {
        REG_ROI_LEFT,
        REG_ROI_TOP,
        REG_ROI_RIGHT,
        REG_ROI_BOTTOM,
        REG_STEP_X,
        REG_STEP_Y,
        REG_WIN_WIDTH,
        REG_WIN_HEIGHT
    } reg_idx_t;

    // tok: a pixel occupies this slot; cand: it may still produce a window
    typedef struct packed {
        logic tok;
        logic cand;
    } grid_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] win_y;
        logic [PIX_W-1:0] win_x;
    } win_t;

endpackage

/* src/mwgs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mwgs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read during write to the same entry returns the old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/mwgs_grid_chk.sv */
// Pipelined grid-alignment check: restoring remainder of the origin offsets by the
// grid steps, one quotient bit per stage for both axes. Depends on mwgs_pkg.
`timescale 1ns / 1ps

module mwgs_grid_chk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mwgs_pkg::grid_ctl_t        in_ctl,
    input  mwgs_pkg::win_t             in_win,
    input  logic [mwgs_pkg::PIX_W-1:0] num_x,
    input  logic [mwgs_pkg::PIX_W-1:0] num_y,
    input  logic [mwgs_pkg::PIX_W-1:0] div_x,
    input  logic [mwgs_pkg::PIX_W-1:0] div_y,
    output mwgs_pkg::grid_ctl_t        out_ctl,
    output mwgs_pkg::win_t             out_win
);

    import mwgs_pkg::*;

    localparam int NS = PIX_W;

    grid_ctl_t        ctl_reg [NS];
    grid_ctl_t        ctl_next [NS];
    win_t             win_reg [NS];
    win_t             win_next [NS];
    logic [PIX_W-1:0] rx_reg [NS];
    logic [PIX_W-1:0] rx_next [NS];
    logic [PIX_W-1:0] nx_reg [NS];
    logic [PIX_W-1:0] nx_next [NS];
    logic [PIX_W-1:0] ry_reg [NS];
    logic [PIX_W-1:0] ry_next [NS];
    logic [PIX_W-1:0] ny_reg [NS];
    logic [PIX_W-1:0] ny_next [NS];

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic logic [PIX_W-1:0] rem_step(input logic [PIX_W-1:0] rem,
                                                  input logic nb,
                                                  input logic [PIX_W-1:0] dv);
        logic [PIX_W:0] t;
        t = {rem, nb};
        if (t >= {1'b0, dv})
        begin
            t = t - {1'b0, dv};
        end
        return t[PIX_W-1:0];
    endfunction

    always_comb
    begin
        logic [PIX_W-1:0] rxs;
        logic [PIX_W-1:0] nxs;
        logic [PIX_W-1:0] rys;
        logic [PIX_W-1:0] nys;
        for (int j = 0; j < NS; j++)
        begin
            if (j == 0)
            begin
                rxs         = '0;
                nxs         = num_x;
                rys         = '0;
                nys         = num_y;
                ctl_next[j] = in_ctl;
                win_next[j] = in_win;
            end
            else
            begin
                rxs         = rx_reg[j-1];
                nxs         = nx_reg[j-1];
                rys         = ry_reg[j-1];
                nys         = ny_reg[j-1];
                ctl_next[j] = ctl_reg[j-1];
                win_next[j] = win_reg[j-1];
            end
            rx_next[j] = rem_step(rxs, nxs[PIX_W-1], div_x);
            nx_next[j] = nxs << 1;
            ry_next[j] = rem_step(rys, nys[PIX_W-1], div_y);
            ny_next[j] = nys << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NS; j++)
            begin
                ctl_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < NS; j++)
            begin
                ctl_reg[j] <= ctl_next[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NS; j++)
        begin
            win_reg[j] <= win_next[j];
            rx_reg[j]  <= rx_next[j];
            nx_reg[j]  <= nx_next[j];
            ry_reg[j]  <= ry_next[j];
            ny_reg[j]  <= ny_next[j];
        end
    end

    always_comb
    begin
        out_ctl.tok  = ctl_reg[NS-1].tok;
        out_ctl.cand = ctl_reg[NS-1].cand && (rx_reg[NS-1] == '0) && (ry_reg[NS-1] == '0);
        out_win      = win_reg[NS-1];
    end

endmodule

/* src/masked_window_grid_select_unit.sv */
// Masked window grid selector: one mask pixel per cycle, back to back, while ready is high.
// A window origin passes through the line store read and update, the range check and the
// 10-stage grid remainder before it enters the result queue.
// Throughput: one pixel per cycle while ready; the line store has one read and one write port.
// Reset: registers and queues clear at once; the line store is then swept to zero
// with s_axis_tready low.
`timescale 1ns / 1ps

module masked_window_grid_select_unit #(
    parameter int IMAGE_WIDTH  = mwgs_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = mwgs_pkg::IMAGE_HEIGHT_DEF,
    parameter int MAX_WINDOW   = mwgs_pkg::MAX_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwgs_pkg::CFG_AW-1:0]      paddr,
    input  logic [mwgs_pkg::APB_DW-1:0]      pwdata,
    output logic [mwgs_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    // mask pixels
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mwgs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // pix_x, pix_y, alpha, pad
    // window origins
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mwgs_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // win_x, win_y, pad
);

    import mwgs_pkg::*;

    localparam int RAM_DEPTH = (IMAGE_WIDTH < (1 << PIX_W)) ? IMAGE_WIDTH : (1 << PIX_W);
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam int CW        = $clog2(MAX_WINDOW + 1);
    localparam int SW        = PIX_W + 1;
    localparam int LAT       = 2 + PIX_W;
    localparam int FD        = 1 << $clog2(LAT + 2);
    localparam int FPW       = $clog2(FD);
    localparam int OCW       = $clog2(FD + 1);

    // ---------------- configuration registers ----------------
    logic [PIX_W-1:0]   roi_left_reg, roi_top_reg, roi_right_reg, roi_bottom_reg;
    logic [PIX_W-1:0]   step_x_reg, step_y_reg;
    logic [WSIZE_W-1:0] win_width_reg, win_height_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_left_reg   <= ROI_LEFT_RST;
            roi_top_reg    <= ROI_TOP_RST;
            roi_right_reg  <= ROI_RIGHT_RST;
            roi_bottom_reg <= ROI_BOTTOM_RST;
            step_x_reg     <= STEP_X_RST;
            step_y_reg     <= STEP_Y_RST;
            win_width_reg  <= WIN_WIDTH_RST;
            win_height_reg <= WIN_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ROI_LEFT:   roi_left_reg   <= pwdata[PIX_W-1:0];
                REG_ROI_TOP:    roi_top_reg    <= pwdata[PIX_W-1:0];
                REG_ROI_RIGHT:  roi_right_reg  <= pwdata[PIX_W-1:0];
                REG_ROI_BOTTOM: roi_bottom_reg <= pwdata[PIX_W-1:0];
                REG_STEP_X:     step_x_reg     <= pwdata[PIX_W-1:0];
                REG_STEP_Y:     step_y_reg     <= pwdata[PIX_W-1:0];
                REG_WIN_WIDTH:  win_width_reg  <= pwdata[WSIZE_W-1:0];
                REG_WIN_HEIGHT: win_height_reg <= pwdata[WSIZE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROI_LEFT:   prdata = APB_DW'(roi_left_reg);
            REG_ROI_TOP:    prdata = APB_DW'(roi_top_reg);
            REG_ROI_RIGHT:  prdata = APB_DW'(roi_right_reg);
            REG_ROI_BOTTOM: prdata = APB_DW'(roi_bottom_reg);
            REG_STEP_X:     prdata = APB_DW'(step_x_reg);
            REG_STEP_Y:     prdata = APB_DW'(step_y_reg);
            REG_WIN_WIDTH:  prdata = APB_DW'(win_width_reg);
            REG_WIN_HEIGHT: prdata = APB_DW'(win_height_reg);
            default:        prdata = '0;
        endcase
    end

    // effective window size and step
    logic [CW-1:0]    w_eff, h_eff;
    logic [PIX_W-1:0] sx_eff, sy_eff;

    always_comb
    begin
        if (win_width_reg == '0)
            w_eff = CW'(1);
        else if (32'(win_width_reg) > MAX_WINDOW)
            w_eff = CW'(MAX_WINDOW);
        else
            w_eff = CW'(win_width_reg);

        if (win_height_reg == '0)
            h_eff = CW'(1);
        else if (32'(win_height_reg) > MAX_WINDOW)
            h_eff = CW'(MAX_WINDOW);
        else
            h_eff = CW'(win_height_reg);

        sx_eff = (step_x_reg == '0) ? PIX_W'(1) : step_x_reg;
        sy_eff = (step_y_reg == '0) ? PIX_W'(1) : step_y_reg;
    end

    // ---------------- input side ----------------
    logic [PIX_W-1:0]   pix_x, pix_y;
    logic [ALPHA_W-1:0] alpha;
    logic               in_fire, in_image;
    logic               clr_active_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [OCW-1:0]     occ_reg, occ_next;

    assign pix_x = s_axis_tdata[PIX_W-1:0];
    assign pix_y = s_axis_tdata[2*PIX_W-1:PIX_W];
    assign alpha = s_axis_tdata[2*PIX_W+ALPHA_W-1:2*PIX_W];

    // occ counts every pixel in flight plus queued results, so the queue never overflows
    assign s_axis_tready = !clr_active_reg && (occ_reg < OCW'(FD));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_image      = (32'(pix_x) < IMAGE_WIDTH) && (32'(pix_y) < IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(RAM_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: line store read-modify-write ----------------
    logic             s1_tok_reg, s1_live_reg;
    logic [PIX_W-1:0] s1_x_reg, s1_y_reg;
    logic             s1_mask_reg;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [CW-1:0]    fwd_col_reg;
    logic [CW-1:0]    run_reg;
    logic [CW-1:0]    ram_rdata, col_new, run_new;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_wr_addr;
    logic [CW-1:0]    ram_wr_data;
    logic             cand1;

    mwgs_ram #(
        .WIDTH (CW),
        .DEPTH (RAM_DEPTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_fire),
        .rd_addr (pix_x[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign ram_wr_en   = clr_active_reg || s1_live_reg;
    assign ram_wr_addr = clr_active_reg ? clr_addr_reg : s1_x_reg[AW-1:0];
    assign ram_wr_data = clr_active_reg ? '0 : col_new;

    // the RAM returns old data when the pixel in stage 1 writes the same column
    assign fwd_hit_next = in_fire && s1_live_reg && (s1_x_reg[AW-1:0] == pix_x[AW-1:0]);

    always_comb
    begin
        logic [CW-1:0] stored;
        logic [CW-1:0] col_sat;
        logic [CW-1:0] run_old;
        logic [CW-1:0] run_sat;
        logic [SW-1:0] xp1;
        logic [SW-1:0] yp1;

        if (s1_y_reg == '0)
            stored = '0;
        else if (fwd_hit_reg)
            stored = fwd_col_reg;
        else
            stored = ram_rdata;
        col_sat = (stored > h_eff) ? h_eff : stored;
        if (s1_mask_reg)
            col_new = '0;
        else if (col_sat < h_eff)
            col_new = col_sat + CW'(1);
        else
            col_new = col_sat;

        run_old = (s1_x_reg == '0) ? '0 : run_reg;
        run_sat = (run_old > w_eff) ? w_eff : run_old;
        if (col_new < h_eff)
            run_new = '0;
        else if (run_sat < w_eff)
            run_new = run_sat + CW'(1);
        else
            run_new = run_sat;

        xp1   = {1'b0, s1_x_reg} + SW'(1);
        yp1   = {1'b0, s1_y_reg} + SW'(1);
        cand1 = s1_live_reg && (run_new == w_eff) && (xp1 >= SW'(w_eff))
                && (yp1 >= SW'(h_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg  <= 1'b0;
            s1_live_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            run_reg     <= '0;
        end
        else
        begin
            s1_tok_reg  <= in_fire;
            s1_live_reg <= in_fire && in_image;
            fwd_hit_reg <= fwd_hit_next;
            if (s1_live_reg)
            begin
                run_reg <= run_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= pix_x;
        s1_y_reg    <= pix_y;
        s1_mask_reg <= (alpha != '0);
        fwd_col_reg <= col_new;
    end

    // ---------------- stage 2: origin and region check ----------------
    grid_ctl_t        s2_ctl_reg;
    logic [PIX_W-1:0] s2_x_reg, s2_y_reg;
    logic [PIX_W-1:0] ox, oy;
    logic             range_ok;
    grid_ctl_t        gin_ctl, gout_ctl;
    win_t             gin_win, gout_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
        end
        else
        begin
            s2_ctl_reg.tok  <= s1_tok_reg;
            s2_ctl_reg.cand <= cand1;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_x_reg <= s1_x_reg;
        s2_y_reg <= s1_y_reg;
    end

    always_comb
    begin
        logic [SW-1:0] ox_w;
        logic [SW-1:0] oy_w;
        // origin = last pixel + 1 - size; its far edge is the last pixel + 1
        ox_w     = {1'b0, s2_x_reg} + SW'(1) - SW'(w_eff);
        oy_w     = {1'b0, s2_y_reg} + SW'(1) - SW'(h_eff);
        ox       = ox_w[PIX_W-1:0];
        oy       = oy_w[PIX_W-1:0];
        range_ok = (ox >= roi_left_reg) && (s2_x_reg < roi_right_reg)
                   && (oy >= roi_top_reg) && (s2_y_reg < roi_bottom_reg);

        gin_ctl.tok   = s2_ctl_reg.tok;
        gin_ctl.cand  = s2_ctl_reg.cand && range_ok;
        gin_win.win_x = ox;
        gin_win.win_y = oy;
    end

    mwgs_grid_chk u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (gin_ctl),
        .in_win  (gin_win),
        .num_x   (ox - roi_left_reg),
        .num_y   (oy - roi_top_reg),
        .div_x   (sx_eff),
        .div_y   (sy_eff),
        .out_ctl (gout_ctl),
        .out_win (gout_win)
    );

    // ---------------- result queue ----------------
    win_t           fifo_reg [FD];
    logic [FPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OCW-1:0] cnt_reg;
    logic           push, pop;

    assign push          = gout_ctl.tok && gout_ctl.cand;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = OUT_TDATA_W'(fifo_reg[rd_ptr_reg]);

    assign occ_next = occ_reg + OCW'(in_fire) - OCW'(gout_ctl.tok && !push) - OCW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FPW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FPW'(1);
            end
            cnt_reg <= cnt_reg + OCW'(push) - OCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= gout_win;
        end
    end

endmodule

/* src/mwgs_checker.sv */
// Port-level checker for the masked window grid selector, bound to the top level.
// Depends on masked_window_grid_select_unit_macros.svh.
`timescale 1ns / 1ps

`include "masked_window_grid_select_unit_macros.svh"

module mwgs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic out_stall;

    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a stalled result stays offered and unchanged
    `MWGS_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "stalled result dropped")
    `MWGS_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled result changed")

    // line store sweep runs right after reset: no pixel transfer, no result yet
    `MWGS_ASSERT_SAME(a_clear_blocks_input, !$past(rst_n), !s_axis_tready, "ready during clear")
    `MWGS_ASSERT_SAME(a_no_early_result, !$past(rst_n), !m_axis_tvalid, "early result")

endmodule

bind masked_window_grid_select_unit mwgs_checker u_mwgs_checker (.*);

/* sim/window_origin_checker.sv */
// Checker for the masked window grid selector: shadows the register file, predicts
// the window origins of each pixel transfer and compares them with the output stream.
// Depends on mwgs_pkg.
`timescale 1ns / 1ps

module window_origin_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [mwgs_pkg::CFG_AW-1:0]      paddr,
    input  logic [mwgs_pkg::APB_DW-1:0]      pwdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [mwgs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // pix_x, pix_y, alpha, pad
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [mwgs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // win_x, win_y, pad
    output int                               mismatches,
    output int                               outstanding
);

    import mwgs_pkg::*;

    localparam int COLUMNS = IMAGE_WIDTH_DEF;
    localparam int ROWS    = IMAGE_HEIGHT_DEF;
    localparam int MAX_WIN = MAX_WINDOW_DEF;

    logic [WSIZE_W-1:0] clean_rows [COLUMNS];
    logic [WSIZE_W-1:0] clean_cols;
    logic [PIX_W-1:0]   roi_left;
    logic [PIX_W-1:0]   roi_top;
    logic [PIX_W-1:0]   roi_right;
    logic [PIX_W-1:0]   roi_bottom;
    logic [PIX_W-1:0]   step_x;
    logic [PIX_W-1:0]   step_y;
    logic [WSIZE_W-1:0] win_w_reg;
    logic [WSIZE_W-1:0] win_h_reg;

    win_t pending_origins[$];
    win_t new_origin;

    function automatic int clamp_size(logic [WSIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (int'(v) > MAX_WIN)
            return MAX_WIN;
        return int'(v);
    endfunction

    function automatic bit grid_hit(int org, int first, int last, int size, int step);
        int pitch;
        pitch = (step == 0) ? 1 : step;
        if (org < first)
            return 1'b0;
        if (org + size > last)
            return 1'b0;
        return ((org - first) % pitch) == 0;
    endfunction

    // Updates the run counters for one pixel; returns 1 when a window origin results.
    function automatic bit predict_origin(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                          logic [ALPHA_W-1:0] a, output win_t org);
        int w;
        int h;
        int col;
        int run;
        int ox;
        int oy;
        org = '0;
        w = clamp_size(win_w_reg);
        h = clamp_size(win_h_reg);
        if (int'(x) >= COLUMNS || int'(y) >= ROWS)
            return 1'b0;

        // row 0 starts a new image, so the stored count is stale there
        col = (y == 0) ? 0 : int'(clean_rows[x]);
        if (col > h)
            col = h;
        if (a != 0)
            col = 0;
        else if (col < h)
            col++;
        clean_rows[x] = WSIZE_W'(col);

        run = (x == 0) ? 0 : int'(clean_cols);
        if (run > w)
            run = w;
        if (col < h)
            run = 0;
        else if (run < w)
            run++;
        clean_cols = WSIZE_W'(run);

        if (run < w || int'(x) + 1 < w || int'(y) + 1 < h)
            return 1'b0;
        ox = int'(x) - w + 1;
        oy = int'(y) - h + 1;
        if (!grid_hit(ox, int'(roi_left), int'(roi_right), w, int'(step_x)))
            return 1'b0;
        if (!grid_hit(oy, int'(roi_top), int'(roi_bottom), h, int'(step_y)))
            return 1'b0;
        org.win_x = PIX_W'(ox);
        org.win_y = PIX_W'(oy);
        return 1'b1;
    endfunction

    function automatic void check_origin(win_t got);
        win_t want;
        if (pending_origins.size() == 0)
        begin
            mismatches++;
            $display("%0t ns: unexpected window origin: expected none, got x=%0d y=%0d",
                     $time, got.win_x, got.win_y);
        end
        else
        begin
            want = pending_origins.pop_front();
            if (got.win_x != want.win_x)
            begin
                mismatches++;
                $display("%0t ns: win_x mismatch: expected %0d, got %0d",
                         $time, want.win_x, got.win_x);
            end
            if (got.win_y != want.win_y)
            begin
                mismatches++;
                $display("%0t ns: win_y mismatch: expected %0d, got %0d",
                         $time, want.win_y, got.win_y);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < COLUMNS; c++)
                clean_rows[c] = '0;
            clean_cols = '0;
            roi_left   = ROI_LEFT_RST;
            roi_top    = ROI_TOP_RST;
            roi_right  = ROI_RIGHT_RST;
            roi_bottom = ROI_BOTTOM_RST;
            step_x     = STEP_X_RST;
            step_y     = STEP_Y_RST;
            win_w_reg  = WIN_WIDTH_RST;
            win_h_reg  = WIN_HEIGHT_RST;
            pending_origins.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_origin(win_t'(m_axis_tdata[2*PIX_W-1:0]));
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_origin(s_axis_tdata[PIX_W-1:0],
                                   s_axis_tdata[2*PIX_W-1:PIX_W],
                                   s_axis_tdata[2*PIX_W+ALPHA_W-1:2*PIX_W],
                                   new_origin))
                    pending_origins.push_back(new_origin);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[CFG_AW-1:2]))
                    REG_ROI_LEFT:   roi_left   = pwdata[PIX_W-1:0];
                    REG_ROI_TOP:    roi_top    = pwdata[PIX_W-1:0];
                    REG_ROI_RIGHT:  roi_right  = pwdata[PIX_W-1:0];
                    REG_ROI_BOTTOM: roi_bottom = pwdata[PIX_W-1:0];
                    REG_STEP_X:     step_x     = pwdata[PIX_W-1:0];
                    REG_STEP_Y:     step_y     = pwdata[PIX_W-1:0];
                    REG_WIN_WIDTH:  win_w_reg  = pwdata[WSIZE_W-1:0];
                    REG_WIN_HEIGHT: win_h_reg  = pwdata[WSIZE_W-1:0];
                    default: ;
                endcase
            end
        end
        outstanding = pending_origins.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top for masked_window_grid_select_unit: clock, reset, register setup,
// mask pixel stimulus and receiver back-pressure; the checking is in window_origin_checker.
// Depends on mwgs_pkg, masked_window_grid_select_unit and window_origin_checker.
`timescale 1ns / 1ps

module tb;
    import mwgs_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // pix_x, pix_y, alpha, pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // win_x, win_y, pad

    int mismatch_cnt;
    int pending_cnt;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_served = 1'b0;
    int hold_count = 0;
    int cur_roi_left = 0;
    int cur_roi_top = 0;

    masked_window_grid_select_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    window_origin_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatch_cnt),
        .outstanding   (pending_cnt)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("masked_window_grid_select_unit regression: fail");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once requested.
    always @(posedge clk)
    begin
        if (hold_req && !hold_served)
        begin
            m_axis_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_served = 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 48; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 48; end
            default:       begin send_idle_pct = 24; stall_pct = 24; end
        endcase
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        int width;
        logic [APB_DW-1:0] data;
        width = (idx == REG_WIN_WIDTH || idx == REG_WIN_HEIGHT) ? WSIZE_W : PIX_W;
        data = value;
        // bits above the register field are don't-care
        if ($urandom_range(0, 3) == 0)
            data = data | ($urandom << width);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setup(int l, int t, int r, int b, int sx, int sy, int ww, int wh);
        write_reg(REG_ROI_LEFT, l);
        write_reg(REG_ROI_TOP, t);
        write_reg(REG_ROI_RIGHT, r);
        write_reg(REG_ROI_BOTTOM, b);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_WIN_WIDTH, ww);
        write_reg(REG_WIN_HEIGHT, wh);
        cur_roi_left = l;
        cur_roi_top  = t;
    endtask

    task automatic send_pixel(int x, int y, int a);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[PIX_W-1:0] = PIX_W'(x);
        word[2*PIX_W-1:PIX_W] = PIX_W'(y);
        word[2*PIX_W+ALPHA_W-1:2*PIX_W] = ALPHA_W'(a);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Waits until every predicted origin has arrived and the pipeline has emptied.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int frame_origin(int anchor, int len, int extent);
        int hi;
        int pos;
        hi = extent - len;
        case ($urandom_range(0, 2))
            0:       pos = 0;
            1:       pos = anchor - int'($urandom_range(0, 2));
            default: pos = $urandom_range(0, hi);
        endcase
        if (pos < 0)
            pos = 0;
        if (pos > hi)
            pos = hi;
        return pos;
    endfunction

    // Mostly raster-ordered frames near the region corner, some cut short,
    // with bursts of scattered pixels in between.
    task automatic run_random(int budget, int fw_lo, int fw_hi, int fh_lo, int fh_hi,
                              int mask_pct, bit vary_idle);
        int left;
        int fw;
        int fh;
        int x0;
        int y0;
        int cut;
        int count;
        int n;
        left = budget;
        while (left > 0)
        begin
            if (vary_idle)
                set_idle(idle_mode_t'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(3, 12);
                repeat (n)
                    send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1) ? $urandom_range(0, 255) : 0);
                left -= n;
            end
            else
            begin
                fw = $urandom_range(fw_lo, fw_hi);
                fh = $urandom_range(fh_lo, fh_hi);
                x0 = frame_origin(cur_roi_left, fw, IMAGE_WIDTH_DEF);
                y0 = frame_origin(cur_roi_top, fh, IMAGE_HEIGHT_DEF);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, fw * fh) : fw * fh;
                // the last frame of a phase stops at the phase budget
                if (cut > left)
                    cut = left;
                count = 0;
                for (int y = y0; y < y0 + fh && count < cut; y++)
                    for (int x = x0; x < x0 + fw && count < cut; x++)
                    begin
                        send_pixel(x, y,
                                   ($urandom_range(0, 99) < mask_pct) ?
                                   $urandom_range(1, 255) : 0);
                        count++;
                    end
                left -= count;
            end
        end
    endtask

    initial
    begin
        int w;
        int h;
        int l;
        int t;
        int r;
        int b;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        set_idle(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2 windows on a unit grid
        apply_setup(0, 0, 1023, 1023, 1, 1, 2, 2);
        send_pixel(0, 0, 1);          // masked pixel at the start of an image
        send_pixel(1, 0, 0);
        send_pixel(2, 0, 0);
        send_pixel(0, 1, 0);          // row start restarts the column run
        send_pixel(1, 1, 0);
        send_pixel(2, 1, 128);
        send_pixel(0, 2, 0);
        send_pixel(1, 2, 0);
        send_pixel(2, 2, 0);          // window overlaps the masked pixel
        send_pixel(0, 0, 0);          // new image: stored counts ignored
        send_pixel(1021, 0, 0);
        send_pixel(1022, 0, 0);
        send_pixel(1021, 1, 0);
        send_pixel(1022, 1, 0);       // window touching the region's right edge
        send_pixel(1023, 1, 0);       // window would pass the region's right edge
        send_pixel(512, 512, 0);
        send_pixel(0, 1023, 0);
        send_pixel(1023, 1023, 255);
        send_pixel(1023, 1023, 0);
        settle();

        // 1x1 windows: nearly every pixel yields an origin, so the long
        // receiver hold-off backs the block up into its input
        apply_setup(0, 0, 1023, 1023, 1, 1, 1, 1);
        set_idle(IDLE_NONE);
        hold_req = 1'b1;
        run_random(200, 4, 20, 1, 6, 20, 1'b0);
        settle();

        apply_setup(3, 2, 40, 30, 2, 3, 3, 2);
        set_idle(IDLE_SENDER);
        run_random(200, 8, 30, 4, 12, 5, 1'b0);
        settle();

        // zero steps and zero window sizes act as one
        apply_setup(5, 5, 900, 900, 0, 0, 0, 0);
        set_idle(IDLE_RECEIVER);
        run_random(120, 3, 16, 2, 8, 30, 1'b0);
        settle();

        // oversized width clamps to the largest window
        apply_setup(0, 0, 1023, 1023, 1, 1, 255, 0);
        set_idle(IDLE_BOTH);
        run_random(260, 128, 134, 1, 2, 1, 1'b0);
        settle();

        apply_setup(0, 0, 1023, 1023, 1, 1, 1, 128);
        set_idle(IDLE_NONE);
        run_random(260, 1, 3, 128, 131, 1, 1'b0);
        settle();

        // largest steps: only the region corner can be an origin
        apply_setup(1000, 1010, 1023, 1023, 1023, 1023, 4, 3);
        set_idle(IDLE_RECEIVER);
        run_random(120, 6, 24, 4, 13, 3, 1'b0);
        settle();

        // inverted region: nothing may come out
        apply_setup(600, 700, 100, 50, 1, 1, 2, 2);
        set_idle(IDLE_SENDER);
        run_random(90, 3, 12, 2, 6, 10, 1'b0);
        settle();

        repeat (3)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
            l = $urandom_range(0, 1) ? 0 : $urandom_range(0, 40);
            t = $urandom_range(0, 1) ? 0 : $urandom_range(0, 40);
            r = ($urandom_range(0, 3) == 0) ? 1023 : l + $urandom_range(w, 60);
            b = ($urandom_range(0, 3) == 0) ? 1023 : t + $urandom_range(h, 60);
            apply_setup(l, t, r, b, $urandom_range(1, 5), $urandom_range(1, 5), w, h);
            run_random(130, w, w + 10, h, h + 6, 8, 1'b1);
            settle();
        end

        if (mismatch_cnt == 0 && pending_cnt == 0)
            $display("masked_window_grid_select_unit regression: pass");
        else
            $display("masked_window_grid_select_unit regression: fail");
        $finish;
    end

endmodule
